// ===== rtl/core/fdl_pkg.sv =====
package fdl_pkg;

   // field and storage widths
   localparam int AGE_WIDTH          = 16;
   localparam int LENGTH_WIDTH       = 32;
   localparam int CFG_WIDTH          = 16;
   localparam int CMP_WIDTH          = (AGE_WIDTH > CFG_WIDTH) ? AGE_WIDTH : CFG_WIDTH;
   localparam int BYTE_WIDTH         = 8;
   localparam int STATE_WIDTH        = 2;
   localparam int EVENT_WIDTH        = 2;
   localparam int FRAME_LENGTH_WIDTH = 32;
   localparam int COUNT_WIDTH        = 32;
   localparam int HDR_INDEX_WIDTH    = 3;
   localparam int WINDOW_DEPTH       = 4;
   localparam int FILL_WIDTH         = 3;
   localparam int ACC_WIDTH          = 24;

   // configuration port
   localparam int ADDR_WIDTH      = 4;
   localparam int DATA_WIDTH      = 32;
   localparam int CFG_INDEX_WIDTH = 2;

   localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDLE_TIMEOUT  = 2'd0;
   localparam logic [CFG_INDEX_WIDTH-1:0] CFG_STATE_TIMEOUT = 2'd1;
   localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OFF_HOLD      = 2'd2;
   localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IMAGE_GAP     = 2'd3;

   localparam logic [CFG_WIDTH-1:0] IDLE_TIMEOUT_RESET  = 16'd1000;
   localparam logic [CFG_WIDTH-1:0] STATE_TIMEOUT_RESET = 16'd1000;
   localparam logic [CFG_WIDTH-1:0] OFF_HOLD_RESET      = 16'd100;
   localparam logic [CFG_WIDTH-1:0] IMAGE_GAP_RESET     = 16'd500;

   // item kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // detection states
   localparam logic [STATE_WIDTH-1:0] ST_NONE   = 2'd0;
   localparam logic [STATE_WIDTH-1:0] ST_TARGET = 2'd1;
   localparam logic [STATE_WIDTH-1:0] ST_OTHER  = 2'd2;

   // frame events
   localparam logic [EVENT_WIDTH-1:0] EV_NONE   = 2'd0;
   localparam logic [EVENT_WIDTH-1:0] EV_ACCEPT = 2'd1;
   localparam logic [EVENT_WIDTH-1:0] EV_DROP   = 2'd2;
   localparam logic [EVENT_WIDTH-1:0] EV_END    = 2'd3;

   // parse phases
   localparam logic [1:0] PH_SCAN    = 2'd0;
   localparam logic [1:0] PH_STATE   = 2'd1;
   localparam logic [1:0] PH_HEADER  = 2'd2;
   localparam logic [1:0] PH_PAYLOAD = 2'd3;

   // header byte positions
   localparam logic [HDR_INDEX_WIDTH-1:0] HDR_STATE = 3'd0;
   localparam logic [HDR_INDEX_WIDTH-1:0] HDR_CLASS = 3'd1;
   localparam logic [HDR_INDEX_WIDTH-1:0] HDR_CONF  = 3'd2;
   localparam logic [HDR_INDEX_WIDTH-1:0] HDR_LEN0  = 3'd3;
   localparam logic [HDR_INDEX_WIDTH-1:0] HDR_LEN1  = 3'd4;
   localparam logic [HDR_INDEX_WIDTH-1:0] HDR_LEN2  = 3'd5;
   localparam logic [HDR_INDEX_WIDTH-1:0] HDR_LAST  = 3'd6;

   localparam logic [4*BYTE_WIDTH-1:0] MAGIC_IMAGE  = "VSTJ";
   localparam logic [4*BYTE_WIDTH-1:0] MAGIC_STATUS = "VSTS";

   localparam logic [AGE_WIDTH-1:0] AGE_MAX = '1;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] idle_timeout;
      logic [CFG_WIDTH-1:0] state_timeout;
      logic [CFG_WIDTH-1:0] off_hold;
      logic [CFG_WIDTH-1:0] image_gap;
   } cfg_type;

   typedef struct packed {
      logic                   state_valid;
      logic [STATE_WIDTH-1:0] state_next;
      logic                   image_taken;
   } parse_type;

   function automatic logic [AGE_WIDTH-1:0] age_inc(input logic [AGE_WIDTH-1:0] age);
      return (age == AGE_MAX) ? age : age + AGE_WIDTH'(1);
   endfunction

endpackage

// ===== rtl/core/fdl_req_if.sv =====
interface fdl_req_if;
   import fdl_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  kind;
   logic [BYTE_WIDTH-1:0] rx_byte;

   modport source (output valid, kind, rx_byte, input ready);
   modport sink   (input valid, kind, rx_byte, output ready);
endinterface

// ===== rtl/core/fdl_rsp_if.sv =====
interface fdl_rsp_if;
   import fdl_pkg::*;

   logic                          valid;
   logic                          ready;
   logic                          red_led;
   logic                          green_led;
   logic [STATE_WIDTH-1:0]        detection_state;
   logic [EVENT_WIDTH-1:0]        frame_event;
   logic [BYTE_WIDTH-1:0]         frame_class;
   logic [BYTE_WIDTH-1:0]         frame_confidence;
   logic [FRAME_LENGTH_WIDTH-1:0] frame_length;
   logic [COUNT_WIDTH-1:0]        image_count;

   modport source (output valid, red_led, green_led, detection_state, frame_event,
                   frame_class, frame_confidence, frame_length, image_count,
                   input ready);
   modport sink   (input valid, red_led, green_led, detection_state, frame_event,
                   frame_class, frame_confidence, frame_length, image_count,
                   output ready);
endinterface

// ===== rtl/core/fdl_parser.sv =====
module fdl_parser (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step,
   input  logic                                 kind,
   input  logic [fdl_pkg::BYTE_WIDTH-1:0]       rx_byte,
   input  logic [fdl_pkg::AGE_WIDTH-1:0]        image_age,
   input  logic [fdl_pkg::CFG_WIDTH-1:0]        image_gap,
   output fdl_pkg::parse_type                   parse_out,
   output logic [fdl_pkg::EVENT_WIDTH-1:0]      event_code,
   output logic [fdl_pkg::BYTE_WIDTH-1:0]       class_in,
   output logic [fdl_pkg::BYTE_WIDTH-1:0]       conf_in,
   output logic [fdl_pkg::LENGTH_WIDTH-1:0]     length_in,
   output logic [fdl_pkg::COUNT_WIDTH-1:0]      count_in
);
   import fdl_pkg::*;

   logic [BYTE_WIDTH-1:0]      window_ff [WINDOW_DEPTH];
   logic [BYTE_WIDTH-1:0]      window_in [WINDOW_DEPTH];
   logic [FILL_WIDTH-1:0]      fill_ff, fill_in;
   logic [1:0]                 phase_ff, phase_in;
   logic [HDR_INDEX_WIDTH-1:0] hidx_ff, hidx_in;
   logic [BYTE_WIDTH-1:0]      hstate_ff, hstate_in;
   logic [BYTE_WIDTH-1:0]      class_ff, conf_ff;
   logic [ACC_WIDTH-1:0]       acc_ff, acc_in;
   logic [LENGTH_WIDTH-1:0]    length_ff, left_ff, left_in, left_dec;
   logic [COUNT_WIDTH-1:0]     count_ff;
   logic [4*BYTE_WIDTH-1:0]    full_len;
   logic [4*BYTE_WIDTH-1:0]    window_word;
   logic                       window_full;

   always_comb begin
      window_in  = window_ff;
      fill_in    = fill_ff;
      phase_in   = phase_ff;
      hidx_in    = hidx_ff;
      hstate_in  = hstate_ff;
      class_in   = class_ff;
      conf_in    = conf_ff;
      acc_in     = acc_ff;
      length_in  = length_ff;
      left_in    = left_ff;
      count_in   = count_ff;
      event_code = EV_NONE;
      parse_out  = '0;
      left_dec   = (left_ff != '0) ? left_ff - LENGTH_WIDTH'(1) : left_ff;
      full_len   = {rx_byte, acc_ff};
      window_full = 1'b0;
      window_word = '0;

      if (step && kind == KIND_BYTE) begin
         unique case (phase_ff)
            PH_PAYLOAD: begin
               left_in = left_dec;
               if (left_dec == '0) begin
                  phase_in   = PH_SCAN;
                  event_code = EV_END;
               end
            end
            PH_STATE: begin
               phase_in = PH_SCAN;
               if (rx_byte <= BYTE_WIDTH'(ST_OTHER)) begin
                  parse_out.state_valid = 1'b1;
                  parse_out.state_next  = rx_byte[STATE_WIDTH-1:0];
               end
            end
            PH_HEADER: begin
               unique case (hidx_ff)
                  HDR_STATE: hstate_in          = rx_byte;
                  HDR_CLASS: class_in           = rx_byte;
                  HDR_CONF:  conf_in            = rx_byte;
                  HDR_LEN0:  acc_in[7:0]        = rx_byte;
                  HDR_LEN1:  acc_in[15:8]       = rx_byte;
                  HDR_LEN2:  acc_in[23:16]      = rx_byte;
                  default: ;
               endcase
               if (hidx_ff >= HDR_LAST) begin
                  // header complete: commit length, decide accept or drop
                  hidx_in   = HDR_STATE;
                  length_in = full_len[LENGTH_WIDTH-1:0];
                  left_in   = full_len[LENGTH_WIDTH-1:0];
                  phase_in  = PH_PAYLOAD;
                  if (hstate_ff <= BYTE_WIDTH'(ST_OTHER)) begin
                     parse_out.state_valid = 1'b1;
                     parse_out.state_next  = hstate_ff[STATE_WIDTH-1:0];
                  end
                  if (CMP_WIDTH'(image_age) < CMP_WIDTH'(image_gap)) begin
                     event_code = EV_DROP;
                  end else begin
                     event_code            = EV_ACCEPT;
                     parse_out.image_taken = 1'b1;
                     count_in              = count_ff + COUNT_WIDTH'(1);
                  end
               end else begin
                  hidx_in = hidx_ff + HDR_INDEX_WIDTH'(1);
               end
            end
            default: begin
               // scanning: shift byte into the magic window
               if (fill_ff < FILL_WIDTH'(WINDOW_DEPTH)) begin
                  window_in[fill_ff[1:0]] = rx_byte;
                  fill_in = fill_ff + FILL_WIDTH'(1);
               end else begin
                  for (int k = 0; k < WINDOW_DEPTH - 1; k++) begin
                     window_in[k] = window_ff[k+1];
                  end
                  window_in[WINDOW_DEPTH-1] = rx_byte;
               end
               window_full = (fill_ff >= FILL_WIDTH'(WINDOW_DEPTH - 1));
               window_word = {window_in[0], window_in[1], window_in[2], window_in[3]};
               if (window_full && window_word == MAGIC_STATUS) begin
                  phase_in = PH_STATE;
               end else if (window_full && window_word == MAGIC_IMAGE) begin
                  phase_in = PH_HEADER;
                  hidx_in  = HDR_STATE;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
      acc_ff    <= acc_in;
      if (reset) begin
         fill_ff   <= '0;
         phase_ff  <= PH_SCAN;
         hidx_ff   <= HDR_STATE;
         hstate_ff <= '0;
         class_ff  <= '0;
         conf_ff   <= '0;
         length_ff <= '0;
         left_ff   <= '0;
         count_ff  <= '0;
      end else begin
         fill_ff   <= fill_in;
         phase_ff  <= phase_in;
         hidx_ff   <= hidx_in;
         hstate_ff <= hstate_in;
         class_ff  <= class_in;
         conf_ff   <= conf_in;
         length_ff <= length_in;
         left_ff   <= left_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/core/fdl_lamp.sv =====
module fdl_lamp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic                              kind,
   input  fdl_pkg::parse_type                parse_in,
   input  fdl_pkg::cfg_type                  cfg,
   output logic [fdl_pkg::AGE_WIDTH-1:0]     image_age,
   output logic [fdl_pkg::STATE_WIDTH-1:0]   shown_in
);
   import fdl_pkg::*;

   logic [AGE_WIDTH-1:0]   rx_age_ff, rx_age_in;
   logic [AGE_WIDTH-1:0]   st_age_ff, st_age_in;
   logic [AGE_WIDTH-1:0]   act_age_ff, act_age_in;
   logic [AGE_WIDTH-1:0]   img_age_ff, img_age_in;
   logic [STATE_WIDTH-1:0] shown_ff;
   logic [STATE_WIDTH-1:0] next_state;
   logic                   force_off;

   assign image_age = img_age_ff;

   always_comb begin
      rx_age_in  = rx_age_ff;
      st_age_in  = st_age_ff;
      act_age_in = act_age_ff;
      img_age_in = img_age_ff;
      shown_in   = shown_ff;
      next_state = shown_ff;
      force_off  = 1'b0;
      if (step) begin
         if (kind == KIND_TICK) begin
            rx_age_in  = age_inc(rx_age_ff);
            st_age_in  = age_inc(st_age_ff);
            act_age_in = age_inc(act_age_ff);
            img_age_in = age_inc(img_age_ff);
         end else begin
            rx_age_in = '0;
            if (parse_in.image_taken) img_age_in = '0;
            if (parse_in.state_valid) begin
               st_age_in  = '0;
               next_state = parse_in.state_next;
               if (parse_in.state_next != ST_NONE) act_age_in = '0;
            end
         end
         // fail safe on either timeout, decided on the updated ages
         force_off = (CMP_WIDTH'(rx_age_in) > CMP_WIDTH'(cfg.idle_timeout)) ||
                     (CMP_WIDTH'(st_age_in) > CMP_WIDTH'(cfg.state_timeout));
         if (force_off) next_state = ST_NONE;
         // hold the light on for a while after the last active state
         if (next_state == ST_NONE && CMP_WIDTH'(act_age_in) < CMP_WIDTH'(cfg.off_hold)) begin
            shown_in = shown_ff;
         end else if (force_off || (kind == KIND_BYTE && parse_in.state_valid)) begin
            shown_in = next_state;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_age_ff  <= '0;
         st_age_ff  <= '0;
         act_age_ff <= '0;
         img_age_ff <= '0;
         shown_ff   <= ST_NONE;
      end else begin
         rx_age_ff  <= rx_age_in;
         st_age_ff  <= st_age_in;
         act_age_ff <= act_age_in;
         img_age_ff <= img_age_in;
         shown_ff   <= shown_in;
      end
   end

endmodule

// ===== rtl/core/framed_detection_link_led_controller.sv =====
// Channel   Dir  Payload                                           Handshake
// req_ch    in   kind, rx_byte                                     valid/ready
// rsp_ch    out  red_led, green_led, detection_state, frame_event, valid/ready
//                frame_class, frame_confidence, frame_length,
//                image_count
// apb       in   psel, penable, pwrite, paddr, pwdata -> prdata    pready tied high
//
// One beat in, one beat out. A beat waits in the input register, is parsed and
// decided while it sits there, and its result lands in the output register;
// one beat per cycle sustained while the result side does not stall.
// Synchronous reset clears parser phase, ages, counters and shown state.
// A stalled result holds the output register and the input register behind it;
// the input side still takes a beat while the result waits if the input register is free.
module framed_detection_link_led_controller (
   input  logic                              clock,
   input  logic                              reset,
   fdl_req_if.sink                           req_ch,
   fdl_rsp_if.source                         rsp_ch,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [fdl_pkg::ADDR_WIDTH-1:0]    paddr,
   input  logic [fdl_pkg::DATA_WIDTH-1:0]    pwdata,
   output logic [fdl_pkg::DATA_WIDTH-1:0]    prdata,
   output logic                              pready
);
   import fdl_pkg::*;

   cfg_type                   cfg_ff;
   logic                      in_valid_ff;
   logic                      in_kind_ff;
   logic [BYTE_WIDTH-1:0]     in_byte_ff;
   logic                      out_valid_ff;
   logic                      step;
   logic [CFG_INDEX_WIDTH-1:0] cfg_index;

   parse_type                 parse_info;
   logic [EVENT_WIDTH-1:0]    event_code;
   logic [BYTE_WIDTH-1:0]     class_in, conf_in;
   logic [LENGTH_WIDTH-1:0]   length_in;
   logic [COUNT_WIDTH-1:0]    count_in;
   logic [AGE_WIDTH-1:0]      image_age;
   logic [STATE_WIDTH-1:0]    shown_in;

   logic                          red_ff, green_ff;
   logic [STATE_WIDTH-1:0]        state_ff;
   logic [EVENT_WIDTH-1:0]        event_ff;
   logic [BYTE_WIDTH-1:0]         class_ff, conf_ff;
   logic [FRAME_LENGTH_WIDTH-1:0] length_ff;
   logic [COUNT_WIDTH-1:0]        count_ff;

   // configuration registers
   assign pready    = 1'b1;
   assign cfg_index = paddr[ADDR_WIDTH-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.idle_timeout  <= IDLE_TIMEOUT_RESET;
         cfg_ff.state_timeout <= STATE_TIMEOUT_RESET;
         cfg_ff.off_hold      <= OFF_HOLD_RESET;
         cfg_ff.image_gap     <= IMAGE_GAP_RESET;
      end else if (psel && penable && pwrite && pready) begin
         unique case (cfg_index)
            CFG_IDLE_TIMEOUT:  cfg_ff.idle_timeout  <= pwdata[CFG_WIDTH-1:0];
            CFG_STATE_TIMEOUT: cfg_ff.state_timeout <= pwdata[CFG_WIDTH-1:0];
            CFG_OFF_HOLD:      cfg_ff.off_hold      <= pwdata[CFG_WIDTH-1:0];
            default:           cfg_ff.image_gap     <= pwdata[CFG_WIDTH-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (cfg_index)
         CFG_IDLE_TIMEOUT:  prdata = DATA_WIDTH'(cfg_ff.idle_timeout);
         CFG_STATE_TIMEOUT: prdata = DATA_WIDTH'(cfg_ff.state_timeout);
         CFG_OFF_HOLD:      prdata = DATA_WIDTH'(cfg_ff.off_hold);
         default:           prdata = DATA_WIDTH'(cfg_ff.image_gap);
      endcase
   end

   // advance when the output register is empty or being drained
   assign step         = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_kind_ff <= req_ch.kind;
         in_byte_ff <= req_ch.rx_byte;
      end
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   fdl_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .kind       (in_kind_ff),
      .rx_byte    (in_byte_ff),
      .image_age  (image_age),
      .image_gap  (cfg_ff.image_gap),
      .parse_out  (parse_info),
      .event_code (event_code),
      .class_in   (class_in),
      .conf_in    (conf_in),
      .length_in  (length_in),
      .count_in   (count_in)
   );

   fdl_lamp u_lamp (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .kind      (in_kind_ff),
      .parse_in  (parse_info),
      .cfg       (cfg_ff),
      .image_age (image_age),
      .shown_in  (shown_in)
   );

   always_ff @(posedge clock) begin
      if (step) begin
         red_ff    <= (shown_in == ST_TARGET);
         green_ff  <= (shown_in == ST_OTHER);
         state_ff  <= shown_in;
         event_ff  <= event_code;
         class_ff  <= class_in;
         conf_ff   <= conf_in;
         length_ff <= FRAME_LENGTH_WIDTH'(length_in);
         count_ff  <= count_in;
      end
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_ch.valid            = out_valid_ff;
   assign rsp_ch.red_led          = red_ff;
   assign rsp_ch.green_led        = green_ff;
   assign rsp_ch.detection_state  = state_ff;
   assign rsp_ch.frame_event      = event_ff;
   assign rsp_ch.frame_class      = class_ff;
   assign rsp_ch.frame_confidence = conf_ff;
   assign rsp_ch.frame_length     = length_ff;
   assign rsp_ch.image_count      = count_ff;

endmodule

// ===== dv/framed_detection_link_led_controller_test.sv =====
`timescale 1ns / 100ps

module framed_detection_link_led_controller_test;
   import fdl_pkg::*;

   localparam int QUIET_LIMIT = 4000;

   typedef struct packed {
      logic                          red;
      logic                          green;
      logic [STATE_WIDTH-1:0]        state;
      logic [EVENT_WIDTH-1:0]        frame_ev;
      logic [BYTE_WIDTH-1:0]         cls;
      logic [BYTE_WIDTH-1:0]         conf;
      logic [FRAME_LENGTH_WIDTH-1:0] length;
      logic [COUNT_WIDTH-1:0]        count;
   } led_result_type;

   // Tracks the parser, ages and shown state; queues one expected beat per input beat.
   class led_scoreboard;
      logic [CFG_WIDTH-1:0]          idle_limit, status_limit, hold_ms, gap_ms;
      logic [4*BYTE_WIDTH-1:0]       window;
      int unsigned                   fill;
      logic [1:0]                    phase;
      logic [HDR_INDEX_WIDTH-1:0]    hdr_pos;
      logic [BYTE_WIDTH-1:0]         hdr_state, cls, conf;
      logic [LENGTH_WIDTH-1:0]       length, hdr_len, payload_left;
      logic [COUNT_WIDTH-1:0]        images;
      logic [AGE_WIDTH-1:0]          rx_age, status_age, active_age, image_age;
      logic [STATE_WIDTH-1:0]        shown;
      led_result_type                expected_q[$];
      int unsigned                   errors, checked, noted;
      int unsigned                   accepts, drops, ends, target_seen, other_seen;

      function new();
         idle_limit   = IDLE_TIMEOUT_RESET;
         status_limit = STATE_TIMEOUT_RESET;
         hold_ms      = OFF_HOLD_RESET;
         gap_ms       = IMAGE_GAP_RESET;
         window       = '0;
         fill         = 0;
         phase        = PH_SCAN;
         hdr_pos      = HDR_STATE;
         hdr_state    = '0;
         cls          = '0;
         conf         = '0;
         length       = '0;
         hdr_len      = '0;
         payload_left = '0;
         images       = '0;
         rx_age       = '0;
         status_age   = '0;
         active_age   = '0;
         image_age    = '0;
         shown        = ST_NONE;
      endfunction

      function void set_limit(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] value);
         case (idx)
            CFG_IDLE_TIMEOUT:  idle_limit = value;
            CFG_STATE_TIMEOUT: status_limit = value;
            CFG_OFF_HOLD:      hold_ms = value;
            CFG_IMAGE_GAP:     gap_ms = value;
            default: ;
         endcase
      endfunction

      function logic [AGE_WIDTH-1:0] bump(logic [AGE_WIDTH-1:0] age);
         return (age == AGE_MAX) ? age : age + 1'b1;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void note_beat(logic kind, logic [BYTE_WIDTH-1:0] b);
         led_result_type         r;
         logic [STATE_WIDTH-1:0] want;
         logic [EVENT_WIDTH-1:0] ev;
         logic                   taken, forced;
         want   = shown;
         ev     = EV_NONE;
         taken  = 1'b0;
         forced = 1'b0;
         noted++;
         if (kind == KIND_TICK) begin
            rx_age     = bump(rx_age);
            status_age = bump(status_age);
            active_age = bump(active_age);
            image_age  = bump(image_age);
         end else begin
            rx_age = '0;
            case (phase)
               PH_PAYLOAD: begin
                  if (payload_left != 0) payload_left--;
                  if (payload_left == 0) begin
                     phase = PH_SCAN;
                     ev    = EV_END;
                  end
               end
               PH_STATE: begin
                  phase = PH_SCAN;
                  if (b <= 8'd2) begin
                     want  = b[STATE_WIDTH-1:0];
                     taken = 1'b1;
                  end
               end
               PH_HEADER: begin
                  case (hdr_pos)
                     HDR_STATE: hdr_state = b;
                     HDR_CLASS: cls = b;
                     HDR_CONF:  conf = b;
                     default: begin
                        if (hdr_pos == HDR_LEN0) hdr_len = '0;
                        hdr_len[8*(hdr_pos - HDR_LEN0) +: 8] = b;
                     end
                  endcase
                  if (hdr_pos >= HDR_LAST) begin
                     hdr_pos = HDR_STATE;
                     length  = hdr_len;
                     if (hdr_state <= 8'd2) begin
                        want  = hdr_state[STATE_WIDTH-1:0];
                        taken = 1'b1;
                     end
                     if (image_age < gap_ms) begin
                        ev = EV_DROP;
                     end else begin
                        ev        = EV_ACCEPT;
                        image_age = '0;
                        images++;
                     end
                     payload_left = length;
                     phase        = PH_PAYLOAD;
                  end else begin
                     hdr_pos++;
                  end
               end
               default: begin
                  // bytes outside a frame slide through the magic window
                  window = {window[3*BYTE_WIDTH-1:0], b};
                  if (fill < WINDOW_DEPTH) fill++;
                  if (fill == WINDOW_DEPTH && window == MAGIC_STATUS) begin
                     phase = PH_STATE;
                  end else if (fill == WINDOW_DEPTH && window == MAGIC_IMAGE) begin
                     phase   = PH_HEADER;
                     hdr_pos = HDR_STATE;
                  end
               end
            endcase
            if (taken) begin
               status_age = '0;
               if (want != ST_NONE) active_age = '0;
            end
         end
         if (rx_age > idle_limit) begin
            want   = ST_NONE;
            forced = 1'b1;
         end
         if (status_age > status_limit) begin
            want   = ST_NONE;
            forced = 1'b1;
         end
         // hold the lit state while the off hold runs
         if (want == ST_NONE && active_age < hold_ms) begin
            want   = shown;
            forced = 1'b0;
            taken  = 1'b0;
         end
         if ((taken || forced) && want != shown) shown = want;
         r.red      = (shown == ST_TARGET);
         r.green    = (shown == ST_OTHER);
         r.state    = shown;
         r.frame_ev = ev;
         r.cls      = cls;
         r.conf     = conf;
         r.length   = length;
         r.count    = images;
         expected_q.push_back(r);
      endfunction

      task report_mismatch(string what);
         errors++;
         if (errors <= 50) $display("%0t mismatch: %s", $time, what);
      endtask

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report_mismatch($sformatf("beat %0d %s: got 0x%0h, expected 0x%0h",
                                      checked, name, got, want));
      endtask

      task check_result(led_result_type got);
         led_result_type want;
         if (expected_q.size() == 0) begin
            report_mismatch("result beat with nothing outstanding");
            return;
         end
         want = expected_q.pop_front();
         checked++;
         compare_field("red_led", 32'(got.red), 32'(want.red));
         compare_field("green_led", 32'(got.green), 32'(want.green));
         compare_field("detection_state", 32'(got.state), 32'(want.state));
         compare_field("frame_event", 32'(got.frame_ev), 32'(want.frame_ev));
         compare_field("frame_class", 32'(got.cls), 32'(want.cls));
         compare_field("frame_confidence", 32'(got.conf), 32'(want.conf));
         compare_field("frame_length", 32'(got.length), 32'(want.length));
         compare_field("image_count", 32'(got.count), 32'(want.count));
         case (want.frame_ev)
            EV_ACCEPT: accepts++;
            EV_DROP:   drops++;
            EV_END:    ends++;
            default: ;
         endcase
         if (want.state == ST_TARGET) target_seen++;
         if (want.state == ST_OTHER) other_seen++;
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  psel, penable, pwrite;
   logic [ADDR_WIDTH-1:0] paddr;
   logic [DATA_WIDTH-1:0] pwdata;
   logic [DATA_WIDTH-1:0] prdata;
   logic                  pready;
   bit                    steady_flow;
   int unsigned           quiet_cycles;
   led_scoreboard         sb;

   fdl_req_if req_ch();
   fdl_rsp_if rsp_ch();

   framed_detection_link_led_controller dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #1 clock = ~clock;

   always @(negedge clock) begin
      rsp_ch.ready = steady_flow || ($urandom_range(99) >= 28);
   end

   always @(posedge clock) begin
      led_result_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.red      = rsp_ch.red_led;
         got.green    = rsp_ch.green_led;
         got.state    = rsp_ch.detection_state;
         got.frame_ev = rsp_ch.frame_event;
         got.cls      = rsp_ch.frame_class;
         got.conf     = rsp_ch.frame_confidence;
         got.length   = rsp_ch.frame_length;
         got.count    = rsp_ch.image_count;
         sb.check_result(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_beat(input logic kind, input logic [BYTE_WIDTH-1:0] b);
      if (!steady_flow)
         while ($urandom_range(99) < 28) begin
            @(negedge clock);
            req_ch.valid = 1'b0;
         end
      @(negedge clock);
      req_ch.valid   = 1'b1;
      req_ch.kind    = kind;
      req_ch.rx_byte = b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_beat(kind, b);
   endtask

   task automatic send_ticks(input int unsigned n);
      repeat (n) send_beat(KIND_TICK, BYTE_WIDTH'($urandom));
   endtask

   // frame byte, now and then with a tick slipped in behind it
   task automatic send_frame_byte(input logic [BYTE_WIDTH-1:0] b);
      send_beat(KIND_BYTE, b);
      if (!steady_flow && $urandom_range(19) == 0) send_beat(KIND_TICK, BYTE_WIDTH'($urandom));
   endtask

   task automatic send_word(input logic [4*BYTE_WIDTH-1:0] w);
      for (int i = 3; i >= 0; i--) send_frame_byte(w[8*i +: 8]);
   endtask

   task automatic send_image(input logic [BYTE_WIDTH-1:0] st, input logic [BYTE_WIDTH-1:0] c,
                             input logic [BYTE_WIDTH-1:0] k, input logic [31:0] len);
      send_word(MAGIC_IMAGE);
      send_frame_byte(st);
      send_frame_byte(c);
      send_frame_byte(k);
      for (int i = 0; i < 4; i++) send_frame_byte(len[8*i +: 8]);
   endtask

   // finish whatever frame the parser sits in
   task automatic settle_parser();
      while (sb.phase == PH_HEADER || sb.phase == PH_STATE) send_beat(KIND_BYTE, 8'h00);
      while (sb.phase == PH_PAYLOAD) send_frame_byte(BYTE_WIDTH'($urandom));
   endtask

   task automatic pause_until_drained();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                 input logic [CFG_WIDTH-1:0] value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = DATA_WIDTH'(value);
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.set_limit(idx, value);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   function automatic logic [BYTE_WIDTH-1:0] pick_state();
      return ($urandom_range(99) < 85) ? 8'($urandom_range(2)) : 8'($urandom_range(3, 255));
   endfunction

   task automatic random_traffic(input int unsigned n);
      int unsigned start;
      int unsigned pick;
      int unsigned len;
      logic [BYTE_WIDTH-1:0] b;
      start = sb.noted;
      while (sb.noted - start < n) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            send_word(MAGIC_STATUS);
            send_frame_byte(pick_state());
         end else if (pick < 55) begin
            pick = $urandom_range(9);
            len = (pick < 5) ? $urandom_range(3) :
                  (pick < 9) ? $urandom_range(4, 40) : $urandom_range(41, 300);
            send_image(pick_state(), BYTE_WIDTH'($urandom), BYTE_WIDTH'($urandom), len);
         end else if (pick < 80) begin
            send_ticks($urandom_range(1, 40));
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 6)) send_beat(KIND_BYTE, BYTE_WIDTH'($urandom));
         end else begin
            // broken magic: a prefix then a byte that completes neither frame
            b = BYTE_WIDTH'($urandom);
            if (b == "J" || b == "S") b = 8'h00;
            pick = $urandom_range(1, 3);
            send_frame_byte("V");
            if (pick > 1) send_frame_byte("S");
            if (pick > 2) send_frame_byte("T");
            send_frame_byte(b);
         end
         settle_parser();
      end
   endtask

   task automatic run_phase(input logic [CFG_WIDTH-1:0] idle_ms, input logic [CFG_WIDTH-1:0] st_ms,
                            input logic [CFG_WIDTH-1:0] hold, input logic [CFG_WIDTH-1:0] gap,
                            input int unsigned n, input bit steady);
      pause_until_drained();
      write_register(CFG_IDLE_TIMEOUT, idle_ms);
      write_register(CFG_STATE_TIMEOUT, st_ms);
      write_register(CFG_OFF_HOLD, hold);
      write_register(CFG_IMAGE_GAP, gap);
      steady_flow = steady;
      random_traffic(n);
   endtask

   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.kind       = KIND_BYTE;
      req_ch.rx_byte    = '0;
      rsp_ch.ready      = 1'b0;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      steady_flow       = 1'b0;
      quiet_cycles      = 0;
      sb                = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: byte extremes, both kinds, status frames valid and invalid,
      // a header too early after reset with zero length and its closing byte
      send_beat(KIND_BYTE, 8'h00);
      send_beat(KIND_BYTE, 8'hFF);
      send_beat(KIND_TICK, 8'hFF);
      send_word(MAGIC_STATUS);
      send_beat(KIND_BYTE, 8'd1);
      send_word(MAGIC_STATUS);
      send_beat(KIND_BYTE, 8'd3);
      send_image(8'd2, 8'hFF, 8'h00, 32'd0);
      send_beat(KIND_BYTE, 8'h55);

      run_phase(16'd20, 16'd30, 16'd5, 16'd10, 230, 1'b0);
      run_phase(16'd0, 16'd0, 16'd0, 16'd0, 230, 1'b0);
      run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 200, 1'b0);
      run_phase(16'd40, 16'd12, 16'd0, 16'd25, 230, 1'b1);
      run_phase(16'd8, 16'hFFFF, 16'd20, 16'd0, 230, 1'b0);
      run_phase(CFG_WIDTH'($urandom_range(60)), CFG_WIDTH'($urandom_range(60)),
                CFG_WIDTH'($urandom_range(15)), CFG_WIDTH'($urandom_range(40)),
                230, 1'b0);
      run_phase(CFG_WIDTH'($urandom_range(60)), CFG_WIDTH'($urandom_range(60)),
                CFG_WIDTH'($urandom_range(15)), CFG_WIDTH'($urandom_range(40)),
                230, 1'b0);

      // registers near the top of their range: no timeout fires, every image drops
      run_phase(16'hFFFF, 16'hFFFE, 16'd0, 16'hFFFF, 0, 1'b1);
      send_ticks(40);
      send_word(MAGIC_STATUS);
      send_beat(KIND_BYTE, 8'd2);
      send_image(8'd1, 8'h5A, 8'hA5, 32'd2);
      settle_parser();

      run_phase(16'd30, 16'd45, 16'd8, 16'd15, 230, 1'b0);

      // a maximal length keeps the parser in payload for the rest of the run
      send_image(8'd1, BYTE_WIDTH'($urandom), BYTE_WIDTH'($urandom), 32'hFFFF_FFFF);
      repeat (20) send_beat(1'($urandom_range(1)), BYTE_WIDTH'($urandom));

      pause_until_drained();
      repeat (10) @(posedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch($sformatf("%0d expected beats never arrived", sb.pending()));
      $display("checked %0d result beats: %0d images accepted, %0d dropped, %0d payloads closed",
               sb.checked, sb.accepts, sb.drops, sb.ends);
      $display("target shown on %0d beats, other on %0d, under reset values and nine register sets",
               sb.target_seen, sb.other_seen);
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
